// ----- rtl/fsic_pkg.sv -----
// Shared types and constants of the feedback send interval controller.
`default_nettype none

package fsic_pkg;

    // Field widths
    localparam int FB_W        = 31;
    localparam int RATE_W      = 30;
    localparam int IVL_W       = 31;
    localparam int GAIN_W      = 32;
    localparam int PAYLOAD_W   = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 64;

    // Shared divider geometry
    localparam int DIV_QW    = 43;
    localparam int DIV_DW    = 31;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] NS_ITERS    = 6'd30;
    localparam logic [DIV_CNT_W-1:0] GAMMA_ITERS = 6'd43;

    localparam logic [RATE_W-1:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [DIV_QW-1:0] NS_DIVIDEND = {NS_PER_SEC, {(DIV_QW - RATE_W){1'b0}}};
    localparam int                GAMMA_SHIFT = 12;
    localparam logic [IVL_W-1:0]  IVL_MAX     = 31'h7FFF_FFFF;

    // Split of the gamma-term magnitude for the 32x32 multiplier
    localparam int XMAG_W = 44;
    localparam int XSPLIT = 22;
    localparam int BMAG_W = 76;
    localparam logic [BMAG_W-1:0] PROD_LIM = 76'd1 << 62;

    // Reset values
    localparam logic [RATE_W-1:0]    RATE_RESET    = 30'd1000;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 11'd1024;
    localparam logic [GAIN_W-1:0]    DELTA_RESET   = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTROL_MODE  = 3'd0,
        REG_INITIAL_RATE  = 3'd1,
        REG_PAYLOAD_BYTES = 3'd2,
        REG_ALPHA_STEP    = 3'd3,
        REG_DELTA_SCALE   = 3'd4,
        REG_EPSILON_GAIN  = 3'd5,
        REG_BETA_GAIN     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_STEP  = 2'd0,
        MODE_SCALE = 2'd1,
        MODE_PROP  = 2'd2,
        MODE_GAMMA = 2'd3
    } ctrl_mode_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

endpackage

`default_nettype wire

// ----- rtl/fsic_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module fsic_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire fsic_pkg::div_req_t          req,
    input  wire logic [fsic_pkg::DIV_QW-1:0] dividend,  // left-aligned to req.iters bits
    input  wire logic [fsic_pkg::DIV_DW-1:0] divisor,
    output logic                             done,
    output logic [fsic_pkg::DIV_QW-1:0]      quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [fsic_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [fsic_pkg::DIV_QW-1:0]       q_reg;
    logic [fsic_pkg::DIV_QW-1:0]       q_next;
    logic [fsic_pkg::DIV_DW-1:0]       rem_reg;
    logic [fsic_pkg::DIV_DW-1:0]       rem_next;
    logic [fsic_pkg::DIV_DW-1:0]       dsr_reg;
    logic [fsic_pkg::DIV_DW+1:0]       trial;
    logic                              fits;

    assign trial = {1'b0, rem_reg, q_reg[fsic_pkg::DIV_QW-1]} - {2'b0, dsr_reg};
    assign fits  = ~trial[fsic_pkg::DIV_DW+1];

    always_comb begin
        q_next   = {q_reg[fsic_pkg::DIV_QW-2:0], fits};
        rem_next = fits ? trial[fsic_pkg::DIV_DW-1:0]
                        : {rem_reg[fsic_pkg::DIV_DW-2:0], q_reg[fsic_pkg::DIV_QW-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == fsic_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- rtl/feedback_send_interval_control.sv -----
// Top level of the feedback send interval controller.
//
// One transaction per packet sent; the block takes one transaction at a time and holds
// s_tready low while it works. The work is done by one shared restoring divider that
// produces one quotient bit per cycle (1e9 / rate, the gamma term of mode 3 and
// 1e9 / interval), a single 32x32 multiplier (one product in modes 1 and 2, three in
// mode 3, none in mode 0 or while no feedback has been seen) and the sum, clamp and
// push steps; the push waits while the output register is full and m_tready is low.
// The result sits in an output register, so the next packet can be taken while it
// waits for m_tready. Configuration must be written only while the block is idle;
// the block itself does not enforce it. Writing initial_rate also reloads the
// current rate.
`default_nettype none

module feedback_send_interval_control #(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned MAX_PAYLOAD = 1488
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // feedback_occupancy [30:0], feedback_target [61:31], feedback_gamma [92:62]
    input  wire logic [fsic_pkg::IN_TDATA_W-1:0]       s_tdata,
    // feedback_valid [0]
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // interval_ns [30:0], new_rate [60:31]
    output logic [fsic_pkg::OUT_TDATA_W-1:0]           m_tdata,
    // clamped [0]
    output logic                                       m_tuser,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fsic_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fsic_pkg::GAIN_W-1:0]           cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIV_BASE  = 9'b000000010,
        ST_DIV_GAMMA = 9'b000000100,
        ST_MUL       = 9'b000001000,
        ST_ACC       = 9'b000010000,
        ST_SUM       = 9'b000100000,
        ST_CLAMP     = 9'b001000000,
        ST_DIV_RATE  = 9'b010000000,
        ST_PUSH      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration
    fsic_pkg::ctrl_mode_t                mode_reg;
    logic [fsic_pkg::PAYLOAD_W-1:0]      payload_reg;
    logic [fsic_pkg::GAIN_W-1:0]         alpha_reg;
    logic [fsic_pkg::GAIN_W-1:0]         delta_reg;
    logic [fsic_pkg::GAIN_W-1:0]         eps_reg;
    logic [fsic_pkg::GAIN_W-1:0]         beta_reg;

    // Controller state
    logic [fsic_pkg::RATE_W-1:0]         packet_rate_reg;
    logic                                have_fb_reg;
    logic [fsic_pkg::FB_W-1:0]           last_occ_reg;
    logic [fsic_pkg::FB_W-1:0]           last_tgt_reg;
    logic [fsic_pkg::FB_W-1:0]           last_gamma_reg;

    // Captured transaction
    logic                                in_fv_reg;
    logic [fsic_pkg::FB_W-1:0]           in_occ_reg;
    logic [fsic_pkg::FB_W-1:0]           in_tgt_reg;
    logic [fsic_pkg::FB_W-1:0]           in_gamma_reg;

    // Datapath
    logic [fsic_pkg::IVL_W-1:0]          base_reg;
    logic [fsic_pkg::XMAG_W-1:0]         xmag_reg;
    logic                                xneg_reg;
    logic [1:0]                          mstep_reg;
    logic [63:0]                         prod_reg;
    logic                                prod_neg_reg;
    logic signed [65:0]                  term0_reg;
    logic [fsic_pkg::BMAG_W-1:0]         bmag_reg;
    logic signed [65:0]                  v_reg;
    logic signed [65:0]                  v_next;
    logic [fsic_pkg::IVL_W-1:0]          ivl_reg;
    logic                                clamped_reg;

    // Output register
    logic                                out_valid_reg;
    logic [fsic_pkg::IVL_W-1:0]          out_ivl_reg;
    logic [fsic_pkg::RATE_W-1:0]         out_rate_reg;
    logic                                out_clamped_reg;

    // Divider hookup
    fsic_pkg::div_req_t                  div_req;
    logic [fsic_pkg::DIV_QW-1:0]         div_dividend;
    logic [fsic_pkg::DIV_DW-1:0]         div_divisor;
    logic                                div_done;
    logic [fsic_pkg::DIV_QW-1:0]         div_q;

    logic                                in_accept;
    logic                                push_ok;
    logic signed [31:0]                  diff;
    logic                                diff_neg;
    logic                                diff_zero;
    logic [31:0]                         diff_mag;
    logic [31:0]                         eps_mag;
    logic [31:0]                         delta_mag;
    logic [31:0]                         beta_mag;
    logic [1:0]                          nsteps;
    logic                                need_gamma;
    logic [fsic_pkg::PAYLOAD_W-1:0]      p_eff;
    logic [31:0]                         mul_a;
    logic [31:0]                         mul_b;
    logic                                mul_neg;
    logic [63:0]                         mul_p;
    logic signed [65:0]                  sprod;
    logic signed [65:0]                  bq;
    logic signed [65:0]                  alpha_x;
    logic [62:0]                         bsat;
    logic signed [44:0]                  xdiff;
    logic signed [44:0]                  xdiff_n;
    logic                                ivl_low;
    logic                                ivl_high;
    logic [fsic_pkg::IVL_W-1:0]          ivl_w;

    assign in_accept = s_tvalid && s_tready;
    assign push_ok   = !out_valid_reg || m_tready;

    // Occupancy error and operand magnitudes
    assign diff      = {1'b0, last_occ_reg} - {1'b0, last_tgt_reg};
    assign diff_neg  = diff[31];
    assign diff_zero = (diff == 32'sd0);
    assign diff_mag  = diff_neg ? 32'(-diff) : 32'(diff);
    assign eps_mag   = eps_reg[31] ? -eps_reg : eps_reg;
    assign delta_mag = delta_reg[31] ? -delta_reg : delta_reg;
    assign beta_mag  = beta_reg[31] ? -beta_reg : beta_reg;

    assign need_gamma = have_fb_reg && (mode_reg == fsic_pkg::MODE_GAMMA);

    always_comb begin
        if (!have_fb_reg) begin
            nsteps = 2'd0;
        end else begin
            unique case (mode_reg)
                fsic_pkg::MODE_STEP:  nsteps = 2'd0;
                fsic_pkg::MODE_SCALE: nsteps = 2'd1;
                fsic_pkg::MODE_PROP:  nsteps = 2'd1;
                fsic_pkg::MODE_GAMMA: nsteps = 2'd3;
                default:              nsteps = 2'd0;
            endcase
        end
    end

    always_comb begin
        if (payload_reg == '0) begin
            p_eff = fsic_pkg::PAYLOAD_W'(1);
        end else if (32'(payload_reg) > 32'(MAX_PAYLOAD)) begin
            p_eff = fsic_pkg::PAYLOAD_W'(MAX_PAYLOAD);
        end else begin
            p_eff = payload_reg;
        end
    end

    // Shared multiplier operand select: step 0 is delta*base or epsilon*error,
    // steps 1 and 2 are beta times the low and high halves of |base - G|.
    always_comb begin
        priority if (mstep_reg == 2'd0) begin
            if (mode_reg == fsic_pkg::MODE_SCALE) begin
                mul_a   = delta_mag;
                mul_b   = {1'b0, base_reg};
                mul_neg = delta_reg[31];
            end else begin
                mul_a   = eps_mag;
                mul_b   = diff_mag;
                mul_neg = eps_reg[31] ^ diff_neg;
            end
        end else if (mstep_reg == 2'd1) begin
            mul_a   = beta_mag;
            mul_b   = {{(32 - fsic_pkg::XSPLIT){1'b0}}, xmag_reg[fsic_pkg::XSPLIT-1:0]};
            mul_neg = 1'b0;
        end else begin
            mul_a   = beta_mag;
            mul_b   = {{(32 - fsic_pkg::XSPLIT){1'b0}},
                       xmag_reg[fsic_pkg::XMAG_W-1:fsic_pkg::XSPLIT]};
            mul_neg = 1'b0;
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign sprod   = prod_neg_reg ? -$signed({2'b0, prod_reg}) : $signed({2'b0, prod_reg});
    assign bq      = $signed({35'b0, base_reg}) <<< FRAC_BITS;
    assign alpha_x = $signed({{34{alpha_reg[31]}}, alpha_reg});
    assign bsat    = (bmag_reg > fsic_pkg::PROD_LIM) ? 63'(fsic_pkg::PROD_LIM)
                                                     : bmag_reg[62:0];

    assign xdiff   = $signed({14'b0, base_reg}) - $signed({2'b0, div_q});
    assign xdiff_n = -xdiff;

    // Fixed-point interval before clamping
    always_comb begin
        if (!have_fb_reg) begin
            v_next = bq;
        end else begin
            unique case (mode_reg)
                fsic_pkg::MODE_STEP: begin
                    if (diff_neg)       v_next = bq - alpha_x;
                    else if (diff_zero) v_next = bq;
                    else                v_next = bq + alpha_x;
                end
                fsic_pkg::MODE_SCALE: begin
                    if (diff_neg)       v_next = bq - alpha_x;
                    else if (diff_zero) v_next = bq;
                    else                v_next = term0_reg;
                end
                fsic_pkg::MODE_PROP: v_next = term0_reg;
                fsic_pkg::MODE_GAMMA: begin
                    // subtract sign-applied saturated beta product
                    if (beta_reg[31] ^ xneg_reg) v_next = term0_reg + $signed({3'b0, bsat});
                    else                         v_next = term0_reg - $signed({3'b0, bsat});
                end
                default: v_next = bq;
            endcase
        end
    end

    // Clamp to 1 .. 2^31-1 ns
    assign ivl_low  = v_reg < ($signed(66'sd1) <<< FRAC_BITS);
    assign ivl_high = v_reg >= ($signed(66'sd1) <<< (FRAC_BITS + fsic_pkg::IVL_W));
    always_comb begin
        priority if (ivl_low) begin
            ivl_w = fsic_pkg::IVL_W'(1);
        end else if (ivl_high) begin
            ivl_w = fsic_pkg::IVL_MAX;
        end else begin
            ivl_w = v_reg[FRAC_BITS +: fsic_pkg::IVL_W];
        end
    end

    // Divider requests
    always_comb begin
        div_req.start = 1'b0;
        div_req.iters = fsic_pkg::NS_ITERS;
        div_dividend  = fsic_pkg::NS_DIVIDEND;
        div_divisor   = {1'b0, packet_rate_reg};
        unique case (state_reg)
            ST_IDLE: begin
                div_req.start = in_accept;
            end
            ST_DIV_BASE: begin
                div_req.start = div_done && need_gamma;
                div_req.iters = fsic_pkg::GAMMA_ITERS;
                div_dividend  = {last_gamma_reg, {fsic_pkg::GAMMA_SHIFT{1'b0}}};
                div_divisor   = {{(fsic_pkg::DIV_DW - fsic_pkg::PAYLOAD_W){1'b0}}, p_eff};
            end
            ST_CLAMP: begin
                div_req.start = 1'b1;
                div_divisor   = ivl_w;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    fsic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) state_next = ST_DIV_BASE;
            end
            ST_DIV_BASE: begin
                if (div_done) begin
                    priority if (need_gamma)     state_next = ST_DIV_GAMMA;
                    else if (nsteps != 2'd0)     state_next = ST_MUL;
                    else                         state_next = ST_SUM;
                end
            end
            ST_DIV_GAMMA: begin
                if (div_done) state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                if (mstep_reg + 2'd1 == nsteps) state_next = ST_SUM;
                else                            state_next = ST_MUL;
            end
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_DIV_RATE;
            ST_DIV_RATE: begin
                if (div_done) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (push_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= fsic_pkg::MODE_STEP;
            payload_reg     <= fsic_pkg::PAYLOAD_RESET;
            alpha_reg       <= '0;
            delta_reg       <= fsic_pkg::DELTA_RESET;
            eps_reg         <= '0;
            beta_reg        <= '0;
            packet_rate_reg <= fsic_pkg::RATE_RESET;
            have_fb_reg     <= 1'b0;
            last_occ_reg    <= '0;
            last_tgt_reg    <= '0;
            last_gamma_reg  <= '0;
            out_valid_reg   <= 1'b0;
            mstep_reg       <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (fsic_pkg::cfg_reg_t'(cfg_index))
                    fsic_pkg::REG_CONTROL_MODE:
                        mode_reg <= fsic_pkg::ctrl_mode_t'(cfg_data[1:0]);
                    fsic_pkg::REG_INITIAL_RATE:
                        packet_rate_reg <= cfg_data[fsic_pkg::RATE_W-1:0];
                    fsic_pkg::REG_PAYLOAD_BYTES:
                        payload_reg <= cfg_data[fsic_pkg::PAYLOAD_W-1:0];
                    fsic_pkg::REG_ALPHA_STEP:   alpha_reg <= cfg_data;
                    fsic_pkg::REG_DELTA_SCALE:  delta_reg <= cfg_data;
                    fsic_pkg::REG_EPSILON_GAIN: eps_reg   <= cfg_data;
                    fsic_pkg::REG_BETA_GAIN:    beta_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_DIV_BASE || state_reg == ST_DIV_GAMMA) begin
                mstep_reg <= '0;
            end else if (state_reg == ST_ACC) begin
                mstep_reg <= mstep_reg + 2'd1;
            end

            if (state_reg == ST_PUSH && push_ok) begin
                out_valid_reg   <= 1'b1;
                packet_rate_reg <= div_q[fsic_pkg::RATE_W-1:0];
                if (in_fv_reg) begin
                    have_fb_reg    <= 1'b1;
                    last_occ_reg   <= in_occ_reg;
                    last_tgt_reg   <= in_tgt_reg;
                    last_gamma_reg <= in_gamma_reg;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_fv_reg    <= s_tuser;
            in_occ_reg   <= s_tdata[30:0];
            in_tgt_reg   <= s_tdata[61:31];
            in_gamma_reg <= s_tdata[92:62];
        end
        if (state_reg == ST_DIV_BASE && div_done) begin
            base_reg <= (packet_rate_reg == '0) ? fsic_pkg::IVL_MAX
                                                : div_q[fsic_pkg::IVL_W-1:0];
        end
        if (state_reg == ST_DIV_GAMMA && div_done) begin
            xneg_reg <= xdiff[44];
            xmag_reg <= xdiff[44] ? xdiff_n[fsic_pkg::XMAG_W-1:0]
                                  : xdiff[fsic_pkg::XMAG_W-1:0];
        end
        if (state_reg == ST_MUL) begin
            prod_reg     <= mul_p;
            prod_neg_reg <= mul_neg;
        end
        if (state_reg == ST_ACC) begin
            priority if (mstep_reg == 2'd0) begin
                term0_reg <= (mode_reg == fsic_pkg::MODE_SCALE) ? sprod : bq + sprod;
            end else if (mstep_reg == 2'd1) begin
                bmag_reg <= {12'b0, prod_reg};
            end else begin
                bmag_reg <= bmag_reg + ({12'b0, prod_reg} << fsic_pkg::XSPLIT);
            end
        end
        if (state_reg == ST_SUM) begin
            v_reg <= v_next;
        end
        if (state_reg == ST_CLAMP) begin
            ivl_reg     <= ivl_w;
            clamped_reg <= ivl_low || ivl_high;
        end
        if (state_reg == ST_PUSH && push_ok) begin
            out_ivl_reg     <= ivl_reg;
            out_rate_reg    <= div_q[fsic_pkg::RATE_W-1:0];
            out_clamped_reg <= clamped_reg;
        end
    end

    // No transaction is taken while reset is held
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready = aresetn;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b0, out_rate_reg, out_ivl_reg};
    assign m_tuser   = out_clamped_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_DIV_BASE)
        else $error("accepted transaction did not start the base division");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:0] != 31'd0)
        else $error("zero interval presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[30:0] == 31'd1 || m_tdata[30:0] == fsic_pkg::IVL_MAX)
        else $error("clamped flag set on an interval inside the range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PUSH && push_ok |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result push did not load the output register");
`endif

endmodule

`default_nettype wire
